// File: rtl/core/crt_fst_pkg.sv
// ----------------------------------------------------------------------------
// CRT flywheel sync tracker package
// Shared types and constants for the sync tracker: sequencer states, register
// indexes and the beam range limits.
// ----------------------------------------------------------------------------
package crt_fst_pkg;

  // Beam positions are held within 0..BEAM_RANGE.
  localparam logic [31:0] BEAM_RANGE = 32'hf7ffffff;
  // Vertical sync may be taken from the signal only at or above BEAM_Y_LOW, near three quarters of the range.
  localparam logic [31:0] BEAM_Y_LOW = 32'hb9fffffd;
  localparam logic [16:0] MAX17      = 17'h1ffff;
  localparam logic [23:0] MAX24      = 24'hffffff;

  // Horizontal and vertical event codes of a run.
  localparam logic [1:0] EV_NONE  = 2'd0;
  localparam logic [1:0] EV_START = 2'd1;
  localparam logic [1:0] EV_END   = 2'd2;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_TIME_MULT   = 3'd0,
    REG_LINE_LEN    = 3'd1,
    REG_SPD_X_SCAN  = 3'd2,
    REG_SPD_X_RETR  = 3'd3,
    REG_SPD_Y_SCAN  = 3'd4,
    REG_SPD_Y_RETR  = 3'd5
  } reg_idx_e;

  // Sequencer states, one-hot.
  typedef enum logic [10:0] {
    S_IDLE  = 11'b000_0000_0001,
    S_VSET  = 11'b000_0000_0010,
    S_VDIV  = 11'b000_0000_0100,
    S_VEV   = 11'b000_0000_1000,
    S_HFLY  = 11'b000_0001_0000,
    S_HPLAN = 11'b000_0010_0000,
    S_MULX  = 11'b000_0100_0000,
    S_BX    = 11'b000_1000_0000,
    S_BY    = 11'b001_0000_0000,
    S_UPD   = 11'b010_0000_0000,
    S_OUT   = 11'b100_0000_0000
  } state_e;

endpackage

// File: rtl/core/crt_flywheel_sync_tracker_unit.sv
// ----------------------------------------------------------------------------
// CRT flywheel sync tracker
// Each run passes through the bit-serial divider, which times the next vertical
// event, then through single sequencer steps around a 32 by 22 bit multiply for
// the beam moves, and waits for the output. A segment gives up to MAX_RUNS runs.
// Input ready is high only while idle. Reset is asynchronous, active low, and
// restores every register and the tracker state at once.
// ----------------------------------------------------------------------------
module crt_flywheel_sync_tracker_unit
  import crt_fst_pkg::*;
#(
  parameter int MAX_RUNS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        is_sync_i,
  input  logic [11:0] cycle_count_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [21:0] run_length_o,
  output logic [1:0]  h_event_o,
  output logic [1:0]  v_event_o,
  output logic [31:0] beam_x_o,
  output logic [31:0] beam_y_o,
  output logic        in_hsync_o,
  output logic        in_vsync_o,
  output logic        vsync_was_locked_o,
  output logic        last_run_o
);

  localparam int CW = (MAX_RUNS > 1) ? $clog2(MAX_RUNS) : 1;
  localparam logic [CW-1:0] LAST_N = CW'(MAX_RUNS - 1);

  // Configuration registers.
  logic [9:0]  tmul_q;
  logic [15:0] llen_q;
  logic [31:0] sxs_q, sxr_q, sys_q, syr_q;

  // Tracker state.
  logic [31:0] bx_q, by_q;
  logic [16:0] lc_q, exp_q;
  logic [23:0] chg_q;
  logic        hact_q, vact_q, hseen_q, vseen_q, prev_q;

  // Per-segment and per-run working registers.
  state_e      state_q;
  logic        sync_q, hreq_q, vreq_q, first_q;
  logic [21:0] left_q, pv_q, run_q;
  logic [1:0]  ve_q, he_q, vev_q;
  logic [CW-1:0] n_q;
  logic [53:0] prod_q;

  // Divider registers.
  logic [32:0] rem_q;
  logic [31:0] quo_q, div_q;
  logic        divz_q;
  logic [4:0]  dcnt_q;

  // Output register.
  logic        ov_q;
  logic [21:0] o_run_q;
  logic [1:0]  o_he_q, o_ve_q;
  logic        o_lock_q, o_last_q;

  // Figures derived from the line length.
  logic [10:0] win;
  logic [23:0] thr_p;
  logic [16:0] thr;
  logic [18:0] rt_p;
  logic [12:0] rt;
  assign win   = llen_q[15:5];
  assign thr_p = {8'd0, llen_q} * 24'd150;
  assign thr   = thr_p[23:7];
  assign rt_p  = {3'd0, llen_q} * 19'd7;
  assign rt    = rt_p[18:6];

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == S_IDLE);

  // Divider step: one quotient bit per cycle.
  logic [32:0] rem_sh;
  logic        qbit;
  assign rem_sh = {rem_q[31:0], quo_q[31]};
  assign qbit   = (rem_sh >= {1'b0, div_q});

  // Flywheel update of the expected line length on a requested sync.
  logic        hwin;
  logic [17:0] now_v;
  logic [19:0] fly_sum;
  logic [17:0] fly_q2;
  assign hwin    = (lc_q < {6'd0, win}) || ({1'b0, lc_q} + {7'd0, win} >= {1'b0, exp_q});
  assign now_v   = (lc_q < {6'd0, win}) ? {1'b0, exp_q} + {1'b0, lc_q} : {1'b0, lc_q};
  assign fly_sum = {3'd0, exp_q} * 20'd3 + {2'd0, now_v};
  assign fly_q2  = fly_sum[19:2];

  // Horizontal run planning.
  logic [22:0] ph_a, ph_b;
  logic [1:0]  he_a, he_b;
  logic [21:0] run_v;
  always_comb begin
    ph_a = {1'b0, pv_q};
    he_a = EV_NONE;
    if ((lc_q < {4'd0, rt}) && ({6'd0, lc_q} + ph_a >= {10'd0, rt})) begin
      ph_a = {10'd0, rt} - {6'd0, lc_q};
      he_a = EV_END;
    end
    ph_b = ph_a;
    he_b = he_a;
    if ({6'd0, lc_q} + ph_a >= {6'd0, exp_q}) begin
      ph_b = (lc_q >= exp_q) ? 23'd0 : {6'd0, exp_q - lc_q};
      he_b = EV_START;
    end
    run_v = (ph_b < {1'b0, pv_q}) ? ph_b[21:0] : pv_q;
    if ({1'b0, run_v} != ph_b) he_b = EV_NONE;
  end

  // End-of-retrace drift of the expected line when no sync was seen.
  logic [17:0] drift_s;
  assign drift_s = ({1'b0, exp_q} + {8'd0, win[10:1]} + {2'd0, llen_q}) >> 1;

  // Beam move arithmetic on the registered product.
  logic [54:0] bx_e, by_e;
  assign bx_e = {23'd0, bx_q} + {1'b0, prod_q};
  assign by_e = {23'd0, by_q} + {1'b0, prod_q};

  // End-of-run updates.
  logic [21:0] left_n;
  logic [22:0] lc_s;
  logic [24:0] chg_s;
  assign left_n = left_q - run_q;
  assign lc_s   = {6'd0, lc_q} + {1'b0, run_q};
  assign chg_s  = {1'b0, chg_q} + {3'd0, run_q};

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tmul_q <= 10'd1;
      llen_q <= 16'd1024;
      sxs_q  <= 32'd4063232;
      sxr_q  <= 32'd37132000;
      sys_q  <= 32'd12000;
      syr_q  <= 32'd406000;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_TIME_MULT:  tmul_q <= cfg_data_i[9:0];
        REG_LINE_LEN:   llen_q <= cfg_data_i[15:0];
        REG_SPD_X_SCAN: sxs_q  <= cfg_data_i;
        REG_SPD_X_RETR: sxr_q  <= cfg_data_i;
        REG_SPD_Y_SCAN: sys_q  <= cfg_data_i;
        REG_SPD_Y_RETR: syr_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Sequencer and tracker state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      bx_q     <= '0;
      by_q     <= '0;
      lc_q     <= '0;
      exp_q    <= 17'd1024;
      chg_q    <= '0;
      hact_q   <= 1'b0;
      vact_q   <= 1'b0;
      hseen_q  <= 1'b0;
      vseen_q  <= 1'b0;
      prev_q   <= 1'b0;
      ov_q     <= 1'b0;
      n_q      <= '0;
      first_q  <= 1'b0;
      sync_q   <= 1'b0;
      hreq_q   <= 1'b0;
      vreq_q   <= 1'b0;
      left_q   <= '0;
      dcnt_q   <= '0;
      rem_q    <= '0;
      quo_q    <= '0;
      div_q    <= '0;
      divz_q   <= 1'b0;
      pv_q     <= '0;
      ve_q     <= EV_NONE;
      run_q    <= '0;
      he_q     <= EV_NONE;
      vev_q    <= EV_NONE;
      prod_q   <= '0;
      o_run_q  <= '0;
      o_he_q   <= EV_NONE;
      o_ve_q   <= EV_NONE;
      o_lock_q <= 1'b0;
      o_last_q <= 1'b0;
    end else begin
      case (state_q)
        // Accept a segment and scale its length.
        S_IDLE: begin
          if (in_valid_i) begin
            sync_q  <= is_sync_i;
            hreq_q  <= !prev_q && is_sync_i;
            vreq_q  <= prev_q;
            prev_q  <= is_sync_i;
            left_q  <= {10'd0, cycle_count_i} * {12'd0, tmul_q};
            first_q <= 1'b1;
            n_q     <= '0;
            if ((cycle_count_i != '0) && (tmul_q != '0)) state_q <= S_VSET;
          end
        end
        // Load the divider with the distance to the next vertical edge.
        S_VSET: begin
          if (!vact_q) begin
            quo_q  <= BEAM_RANGE - ((by_q > BEAM_RANGE) ? BEAM_RANGE : by_q);
            div_q  <= sys_q;
            divz_q <= (sys_q == '0);
          end else begin
            quo_q  <= by_q;
            div_q  <= syr_q;
            divz_q <= (syr_q == '0);
          end
          rem_q   <= '0;
          dcnt_q  <= '0;
          state_q <= S_VDIV;
        end
        S_VDIV: begin
          rem_q  <= qbit ? rem_sh - {1'b0, div_q} : rem_sh;
          quo_q  <= {quo_q[30:0], qbit};
          dcnt_q <= dcnt_q + 5'd1;
          if (dcnt_q == 5'd31) state_q <= S_VEV;
        end
        // Vertical event: signal-driven vsync or beam reaching its limit.
        S_VEV: begin
          logic [21:0] pv;
          logic [1:0]  ve;
          pv = left_q;
          ve = EV_NONE;
          if (first_q && vreq_q && !vact_q && (chg_q >= {7'd0, thr}) &&
              (by_q >= BEAM_Y_LOW)) begin
            pv = '0;
            ve = EV_START;
            vseen_q <= 1'b1;
          end
          if (!divz_q && (quo_q < {10'd0, pv})) begin
            pv = quo_q[21:0];
            ve = vact_q ? EV_END : EV_START;
          end
          pv_q    <= pv;
          ve_q    <= ve;
          state_q <= S_HFLY;
        end
        // Flywheel pull toward a sync edge inside the window.
        S_HFLY: begin
          if (first_q && hreq_q && hwin) begin
            hseen_q <= 1'b1;
            exp_q   <= (fly_q2 > {1'b0, MAX17}) ? MAX17 : fly_q2[16:0];
          end
          state_q <= S_HPLAN;
        end
        S_HPLAN: begin
          run_q   <= run_v;
          he_q    <= he_b;
          vev_q   <= (run_v == pv_q) ? ve_q : EV_NONE;
          state_q <= S_MULX;
        end
        S_MULX: begin
          prod_q  <= run_q * (hact_q ? sxr_q : sxs_q);
          state_q <= S_BX;
        end
        S_BX: begin
          if (hact_q) begin
            bx_q <= (prod_q >= {22'd0, bx_q}) ? '0 : bx_q - prod_q[31:0];
          end else begin
            bx_q <= (bx_e > {23'd0, BEAM_RANGE}) ? BEAM_RANGE : bx_e[31:0];
          end
          prod_q  <= run_q * (vact_q ? syr_q : sys_q);
          state_q <= S_BY;
        end
        S_BY: begin
          if (vact_q) begin
            by_q <= (prod_q >= {22'd0, by_q}) ? '0 : by_q - prod_q[31:0];
          end else begin
            by_q <= (by_e > {23'd0, BEAM_RANGE}) ? BEAM_RANGE : by_e[31:0];
          end
          state_q <= S_UPD;
        end
        // Counters, capacitor, flags and the result register.
        S_UPD: begin
          left_q  <= left_n;
          first_q <= 1'b0;
          if (he_q == EV_START) begin
            lc_q   <= '0;
            hact_q <= 1'b1;
          end else begin
            lc_q <= (lc_s > {6'd0, MAX17}) ? MAX17 : lc_s[16:0];
            if (he_q == EV_END) begin
              if (!hseen_q) exp_q <= (drift_s > {1'b0, MAX17}) ? MAX17 : drift_s[16:0];
              hseen_q <= 1'b0;
              hact_q  <= 1'b0;
            end
          end
          o_lock_q <= (vev_q == EV_END) && vseen_q;
          if (vev_q == EV_START) begin
            vact_q <= 1'b1;
            chg_q  <= '0;
          end else begin
            if (sync_q && !vact_q) begin
              chg_q <= (chg_s > {1'b0, MAX24}) ? MAX24 : chg_s[23:0];
            end else begin
              chg_q <= ({2'd0, run_q} >= chg_q) ? '0 : chg_q - {2'd0, run_q};
            end
            if (vev_q == EV_END) begin
              vact_q   <= 1'b0;
              vseen_q  <= 1'b0;
            end
          end
          o_run_q  <= run_q;
          o_he_q   <= he_q;
          o_ve_q   <= vev_q;
          o_last_q <= (left_n == '0) || (n_q == LAST_N);
          ov_q     <= 1'b1;
          state_q  <= S_OUT;
        end
        // Hold the result until the request is taken.
        S_OUT: begin
          if (out_ready_i) begin
            ov_q <= 1'b0;
            n_q  <= n_q + CW'(1);
            state_q <= o_last_q ? S_IDLE : S_VSET;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o        = ov_q;
  assign run_length_o       = o_run_q;
  assign h_event_o          = o_he_q;
  assign v_event_o          = o_ve_q;
  assign beam_x_o           = bx_q;
  assign beam_y_o           = by_q;
  assign in_hsync_o         = hact_q;
  assign in_vsync_o         = vact_q;
  assign vsync_was_locked_o = o_lock_q;
  assign last_run_o         = o_last_q;

endmodule
